// File: src/overwriting_message_ring_queue_assert.svh
// Assertion macros for the overwriting message ring queue.
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is low.
`ifndef OVERWRITING_MESSAGE_RING_QUEUE_ASSERT_SVH
`define OVERWRITING_MESSAGE_RING_QUEUE_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define ORMQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ormq same-cycle check failed");

// Consequence must hold in the cycle after the antecedent.
`define ORMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ormq next-cycle check failed");

`endif

// File: src/ormq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ormq_pkg
// Types and constants shared by the overwriting message ring queue.
// ----------------------------------------------------------------------------
package ormq_pkg;

	// Ring geometry; the request and response field widths pin these.
	localparam int SLOTS      = 8;
	localparam int SLOT_BYTES = 512;

	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int FILL_W   = $clog2(SLOT_BYTES + 1);
	localparam int ADDR_W   = $clog2(SLOTS * SLOT_BYTES);
	localparam int BYTE_W   = 8;
	localparam int OFFSET_W = 9;
	localparam int FLEN_W   = 10;
	localparam int TAIL_W   = 3;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_COMMIT = 2'd1,
		CMD_READ   = 2'd2,
		CMD_DROP   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_EMPTY     = 3'd1,
		STAT_TOO_LONG  = 3'd2,
		STAT_OVERWRITE = 3'd3,
		STAT_PAST_LEN  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LEN,
		ST_RESP
	} state_t;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		next_slot = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + SLOT_W'(1);
	endfunction

endpackage

// File: src/ormq_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ormq_in_if
// Request channel: one byte or queue command per request.
// ----------------------------------------------------------------------------
interface ormq_in_if import ormq_pkg::*; ();
	logic                valid;
	logic                ready;
	cmd_t                command;
	logic [BYTE_W-1:0]   data_byte;
	logic [OFFSET_W-1:0] read_offset;

	modport source (output valid, command, data_byte, read_offset, input ready);
	modport sink   (input valid, command, data_byte, read_offset, output ready);
endinterface

// File: src/ormq_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ormq_out_if
// Response channel: status and queue view after each request.
// ----------------------------------------------------------------------------
interface ormq_out_if import ormq_pkg::*; ();
	logic              valid;
	logic              ready;
	status_t           status;
	logic [BYTE_W-1:0] read_byte;
	logic [FLEN_W-1:0] front_length;
	logic [TAIL_W-1:0] tail_index;
	logic              is_empty;
	logic              is_full;

	modport source (output valid, status, read_byte, front_length, tail_index,
		is_empty, is_full, input ready);
	modport sink   (input valid, status, read_byte, front_length, tail_index,
		is_empty, is_full, output ready);
endinterface

// File: src/overwriting_message_ring_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_message_ring_queue
// Ring of message slots that overwrites the oldest message when full.
// ----------------------------------------------------------------------------
//  channel   modport  direction  carries
//  in_req    sink     in         command, data_byte, read_offset
//  out_rsp   source   out        status, read_byte, front_length, tail_index,
//                                is_empty, is_full
//
//  Every request passes through accept, execute (byte or length write, byte
//  read, or pointer update), front-length lookup and response, in order; the
//  length memory's registered read puts the lookup after the execute step.
//  Reset clears the pointers, the pending fill count and the overlong flag;
//  the memories are not cleared, and only written entries reach a response.
//  A response waits in its output register while the sink stalls; the next
//  request is still taken, and its response stage holds until the register frees.
// ----------------------------------------------------------------------------
module overwriting_message_ring_queue import ormq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ormq_in_if.sink    in_req,
	ormq_out_if.source out_rsp
);
	logic              byte_we, byte_re;
	logic [ADDR_W-1:0] byte_waddr, byte_raddr;
	logic [BYTE_W-1:0] byte_wdata, byte_rdata;
	logic              len_we, len_re;
	logic [SLOT_W-1:0] len_waddr, len_raddr;
	logic [FILL_W-1:0] len_wdata, len_rdata;

	// Sequence each request and own the ring pointers.
	ormq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_req     (in_req),
		.out_rsp    (out_rsp),
		.byte_we    (byte_we),
		.byte_waddr (byte_waddr),
		.byte_wdata (byte_wdata),
		.byte_re    (byte_re),
		.byte_raddr (byte_raddr),
		.byte_rdata (byte_rdata),
		.len_we     (len_we),
		.len_waddr  (len_waddr),
		.len_wdata  (len_wdata),
		.len_re     (len_re),
		.len_raddr  (len_raddr),
		.len_rdata  (len_rdata)
	);

	// Message bytes, slot-major: slot s, byte b at s*SLOT_BYTES+b.
	ormq_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (SLOTS * SLOT_BYTES)
	) u_byte_ram (
		.clk   (clk),
		.we    (byte_we),
		.waddr (byte_waddr),
		.wdata (byte_wdata),
		.re    (byte_re),
		.raddr (byte_raddr),
		.rdata (byte_rdata)
	);

	// One committed length per slot.
	ormq_ram #(
		.WIDTH (FILL_W),
		.DEPTH (SLOTS)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.re    (len_re),
		.raddr (len_raddr),
		.rdata (len_rdata)
	);
endmodule

// File: src/ormq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ormq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ormq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Hold read data until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: src/ormq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ormq_ctrl
// Command sequencer: ring pointers, pending fill, memory access, response.
// ----------------------------------------------------------------------------
module ormq_ctrl import ormq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	ormq_in_if.sink            in_req,
	ormq_out_if.source         out_rsp,
	output logic               byte_we,
	output logic [ADDR_W-1:0]  byte_waddr,
	output logic [BYTE_W-1:0]  byte_wdata,
	output logic               byte_re,
	output logic [ADDR_W-1:0]  byte_raddr,
	input  logic [BYTE_W-1:0]  byte_rdata,
	output logic               len_we,
	output logic [SLOT_W-1:0]  len_waddr,
	output logic [FILL_W-1:0]  len_wdata,
	output logic               len_re,
	output logic [SLOT_W-1:0]  len_raddr,
	input  logic [FILL_W-1:0]  len_rdata
);
	state_t state_q, state_d;

	logic [SLOT_W-1:0]   head_q, tail_q, head_d, tail_d;
	logic [FILL_W-1:0]   fill_q, fill_d;
	logic                over_q, over_d;
	cmd_t                cmd_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [OFFSET_W-1:0] off_q;
	status_t             status_q, status_d;

	logic                out_valid_q;
	logic                out_load;
	status_t             rsp_status;
	logic [BYTE_W-1:0]   rsp_byte;
	logic [FLEN_W-1:0]   rsp_flen;

	logic [SLOT_W-1:0]   wslot, fslot;
	logic                ring_empty, ring_full, off_past;

	assign wslot      = next_slot(tail_q);
	assign fslot      = next_slot(head_q);
	assign ring_empty = (head_q == tail_q);
	assign ring_full  = (wslot == head_q);
	assign off_past   = (FILL_W'(off_q) >= len_rdata) ||
		(FILL_W'(off_q) >= FILL_W'(SLOT_BYTES));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_req.valid) state_d = ST_EXEC;
			end
			ST_EXEC: state_d = ST_LEN;
			ST_LEN:  state_d = ST_RESP;
			ST_RESP: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs: memory accesses and queue updates.
	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		fill_d     = fill_q;
		over_d     = over_q;
		status_d   = status_q;
		byte_we    = 1'b0;
		byte_waddr = ADDR_W'(wslot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(fill_q);
		byte_wdata = byte_q;
		byte_re    = 1'b0;
		byte_raddr = ADDR_W'(fslot) * ADDR_W'(SLOT_BYTES) + ADDR_W'(off_q);
		len_we     = 1'b0;
		len_waddr  = wslot;
		len_wdata  = fill_q;
		len_re     = (state_q == ST_LEN);
		len_raddr  = fslot;
		if (state_q == ST_EXEC) begin
			status_d = STAT_OK;
			unique case (cmd_q)
				CMD_APPEND: begin
					if (fill_q < FILL_W'(SLOT_BYTES)) begin
						byte_we = 1'b1;
						fill_d  = fill_q + FILL_W'(1);
					end else begin
						over_d = 1'b1;
					end
				end
				CMD_COMMIT: begin
					if (over_q) begin
						status_d = STAT_TOO_LONG;
					end else begin
						if (ring_full) begin
							status_d = STAT_OVERWRITE;
							head_d   = fslot;
						end
						len_we = 1'b1;
						tail_d = wslot;
					end
					fill_d = '0;
					over_d = 1'b0;
				end
				CMD_READ: begin
					byte_re = !ring_empty && (FILL_W'(off_q) < FILL_W'(SLOT_BYTES));
				end
				CMD_DROP: begin
					if (ring_empty) begin
						status_d = STAT_EMPTY;
					end else begin
						head_d = fslot;
					end
				end
				default: ;
			endcase
		end
	end

	// Response fields, formed once the front length is back.
	always_comb begin
		rsp_status = status_q;
		rsp_byte   = '0;
		rsp_flen   = ring_empty ? '0 : FLEN_W'(len_rdata);
		if (cmd_q == CMD_READ) begin
			if (ring_empty) begin
				rsp_status = STAT_EMPTY;
			end else if (off_past) begin
				rsp_status = STAT_PAST_LEN;
			end else begin
				rsp_status = STAT_OK;
				rsp_byte   = byte_rdata;
			end
		end
	end

	assign out_load     = (state_q == ST_RESP) && (!out_valid_q || out_rsp.ready);
	assign in_req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			fill_q      <= '0;
			over_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			fill_q  <= fill_d;
			over_q  <= over_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_req.valid && in_req.ready) begin
			cmd_q  <= in_req.command;
			byte_q <= in_req.data_byte;
			off_q  <= in_req.read_offset;
		end
		status_q <= status_d;
		if (out_load) begin
			out_rsp.status       <= rsp_status;
			out_rsp.read_byte    <= rsp_byte;
			out_rsp.front_length <= rsp_flen;
			out_rsp.tail_index   <= TAIL_W'(tail_q);
			out_rsp.is_empty     <= ring_empty;
			out_rsp.is_full      <= ring_full;
		end
	end

	assign out_rsp.valid = out_valid_q;
endmodule

// File: src/ormq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ormq_checker
// Port-level checks on the overwriting message ring queue.
// ----------------------------------------------------------------------------
`include "overwriting_message_ring_queue_assert.svh"

module ormq_checker import ormq_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [2:0]        status,
	input logic [BYTE_W-1:0] read_byte,
	input logic [FLEN_W-1:0] front_length,
	input logic              is_empty,
	input logic              is_full
);
	`ORMQ_ASSERT_SAME(a_empty_full_excl, clk, arst_n, out_valid, !(is_empty && is_full))
	`ORMQ_ASSERT_SAME(a_empty_no_length, clk, arst_n, out_valid && is_empty, front_length == '0)
	`ORMQ_ASSERT_SAME(a_byte_only_ok, clk, arst_n, out_valid && (read_byte != '0), status == STAT_OK)
	`ORMQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`ORMQ_ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(read_byte) && $stable(front_length))
endmodule

bind overwriting_message_ring_queue ormq_checker u_ormq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_req.valid),
	.in_ready     (in_req.ready),
	.out_valid    (out_rsp.valid),
	.out_ready    (out_rsp.ready),
	.status       (out_rsp.status),
	.read_byte    (out_rsp.read_byte),
	.front_length (out_rsp.front_length),
	.is_empty     (out_rsp.is_empty),
	.is_full      (out_rsp.is_full)
);
